/* sv/srn_pkg.sv */
// ----------------------------------------------------------------------------
// srn_pkg
// shared types and constants for the sample range normalizer
// ----------------------------------------------------------------------------
package srn_pkg;

  localparam int FIELD_BITS      = 32;
  localparam int LINE_WIDTH_BITS = 13;
  localparam int ZERO_BYTES_BITS = 14;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = LINE_WIDTH_BITS;

  localparam logic [7:0] BYTE_MAX  = 8'd255;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COMPLEX_MODE = 2'd1;

  // request function codes
  localparam logic FUNC_RANGE = 1'b0;
  localparam logic FUNC_EMIT  = 1'b1;

  typedef struct packed {
    logic                          func;
    logic signed [FIELD_BITS-1:0]  sample_real;
    logic signed [FIELD_BITS-1:0]  sample_imag;
  } req_t;

  typedef struct packed {
    logic [7:0]                    blue_byte;
    logic [7:0]                    green_byte;
    logic [ZERO_BYTES_BITS-1:0]    zero_bytes;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RANGE,
    S_EMIT_INC,
    S_SCALE,
    S_MOD_GO,
    S_MOD_RUN,
    S_RE_GO,
    S_RE_RUN,
    S_IM_GO,
    S_IM_RUN,
    S_OUT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DIV_MOD,
    DIV_RE,
    DIV_IM
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     range_upd;
    logic     emit_inc;
    logic     scale;
    logic     div_start;
    logic     take;
    div_sel_t div_sel;
    logic     out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cplx;
  } dp_status_t;

endpackage

/* sv/sample_range_normalize_to_bmp_pixels.sv */
// ----------------------------------------------------------------------------
// sample_range_normalize_to_bmp_pixels
// min/max range tracking and 8-bit normalization of samples into bmp pixels
// ----------------------------------------------------------------------------
// range request: updates the extremes and sample count, then returns to idle; no result
// emit request: uses the one shared radix-2 divider for count mod line width,
//   then the real scaling and, in complex mode, the imaginary scaling
// one request at a time; result strobe lasts one cycle, receiver cannot stall
// reset clears extremes, counters, line width to 1 and real mode
module sample_range_normalize_to_bmp_pixels #(
  parameter int SAMPLE_WIDTH    = 32,
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  srn_pkg::req_t                       req,
  // result channel
  output logic                                res_valid,
  output srn_pkg::res_t                       res,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srn_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [srn_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import srn_pkg::*;

  logic [LINE_WIDTH_BITS-1:0] line_width;
  logic                       complex_mode;
  dp_cmd_t                    cmd;
  dp_status_t                 status;

  // the user must write config only while idle; the block does not enforce it, so always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_BITS'(1);
      complex_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      // unknown indexes are dropped
      unique case (cfg_index)
        CFG_LINE_WIDTH:   line_width   <= cfg_data[LINE_WIDTH_BITS-1:0];
        CFG_COMPLEX_MODE: complex_mode <= cfg_data[0];
        default:          line_width   <= line_width;
      endcase
    end
  end

  // sequencer: accepts a request when idle and steps the datapath
  srn_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (req.func),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // datapath: extremes, counters, shared divider and result register
  srn_dp #(
    .SW   (SAMPLE_WIDTH),
    .MAXP (MAX_LINE_PIXELS),
    .CW   (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req          (req),
    .line_width   (line_width),
    .complex_mode (complex_mode),
    .res_valid    (res_valid),
    .res          (res)
  );

endmodule

/* sv/srn_ctrl.sv */
// ----------------------------------------------------------------------------
// srn_ctrl
// sequencer for range and emit requests
// ----------------------------------------------------------------------------
module srn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                func,
  output logic                busy,
  output srn_pkg::dp_cmd_t    cmd,
  input  srn_pkg::dp_status_t status
);
  import srn_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_MOD;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = (func == FUNC_EMIT) ? S_EMIT_INC : S_RANGE;
        end
      end
      S_RANGE: begin
        cmd.range_upd = 1'b1;
        state_next    = S_IDLE;
      end
      S_EMIT_INC: begin
        cmd.emit_inc = 1'b1;
        state_next   = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_MOD_GO;
      end
      S_MOD_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_MOD_RUN;
      end
      S_MOD_RUN: begin
        if (status.div_done) begin
          cmd.take   = 1'b1;
          state_next = S_RE_GO;
        end
      end
      S_RE_GO: begin
        cmd.div_sel   = DIV_RE;
        cmd.div_start = 1'b1;
        state_next    = S_RE_RUN;
      end
      S_RE_RUN: begin
        cmd.div_sel = DIV_RE;
        if (status.div_done) begin
          cmd.take   = 1'b1;
          state_next = status.cplx ? S_IM_GO : S_OUT;
        end
      end
      S_IM_GO: begin
        cmd.div_sel   = DIV_IM;
        cmd.div_start = 1'b1;
        state_next    = S_IM_RUN;
      end
      S_IM_RUN: begin
        cmd.div_sel = DIV_IM;
        if (status.div_done) begin
          cmd.take   = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        cmd.out    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/srn_div.sv */
// ----------------------------------------------------------------------------
// srn_div
// shared radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module srn_div #(
  parameter int DW  = 32,
  parameter int NW  = 32,
  parameter int SCW = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DW-1:0]  rem_init,
  input  logic [NW-1:0]  bits_init,
  input  logic [SCW-1:0] steps,
  input  logic [DW-1:0]  divisor,
  output logic           done,
  output logic [DW-1:0]  rem,
  output logic [NW-1:0]  quo
);
  import srn_pkg::*;

  logic [DW-1:0]  dvs;
  logic [NW-1:0]  sh;
  logic [SCW-1:0] cnt;
  logic           run;
  logic [DW:0]    trial;
  logic [DW:0]    sub;
  logic           ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, sh[NW-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign sub   = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == SCW'(1));
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == SCW'(1))) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      sh  <= bits_init;
      quo <= '0;
      cnt <= steps;
      dvs <= divisor;
    end else if (run) begin
      rem <= ge ? sub[DW-1:0] : trial[DW-1:0];
      sh  <= {sh[NW-2:0], 1'b0};
      quo <= {quo[NW-2:0], ge};
      cnt <= cnt - SCW'(1);
    end
  end

endmodule

/* sv/srn_dp.sv */
// ----------------------------------------------------------------------------
// srn_dp
// datapath: range tracking, scaling operands, row fill and result register
// ----------------------------------------------------------------------------
module srn_dp #(
  parameter int SW   = 32,
  parameter int MAXP = 4096,
  parameter int CW   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  srn_pkg::dp_cmd_t                      cmd,
  output srn_pkg::dp_status_t                   status,
  input  srn_pkg::req_t                         req,
  input  logic [srn_pkg::LINE_WIDTH_BITS-1:0]   line_width,
  input  logic                                  complex_mode,
  output logic                                  res_valid,
  output srn_pkg::res_t                         res
);
  import srn_pkg::*;

  localparam int WW   = $clog2(MAXP + 1);
  localparam int DW   = (SW > WW) ? SW : WW;
  localparam int NW   = CW;
  localparam int SCW  = $clog2(NW + 1);
  localparam int NUMW = SW + 8;
  localparam int ZW   = WW + 3;

  logic signed [SW-1:0] re, im;
  logic signed [SW-1:0] min_re, max_re, min_im, max_im;
  logic [CW-1:0]        smp_cnt, emit_cnt;
  logic [WW-1:0]        w_eff, pos;
  logic [SW-1:0]        diff_re, rng_re, diff_im, rng_im;
  logic                 zero_re, sat_re, zero_im, sat_im;
  logic [NUMW-1:0]      num_re, num_im;
  logic [7:0]           green, blue;
  logic                 cplx;

  logic [DW-1:0]        d_rem_init, d_divisor, d_rem;
  logic [NW-1:0]        d_bits, d_quo;
  logic [SCW-1:0]       d_steps;
  logic                 d_done;

  logic [31:0]          lw_ext;
  logic [WW-1:0]        w_lim;
  logic                 last;
  logic [WW-1:0]        wp;
  logic [ZW-1:0]        zsum;

  // clamp line width into 1..MAXP
  always_comb begin
    lw_ext = 32'(line_width);
    if (lw_ext == 32'd0) begin
      w_lim = WW'(1);
    end else if (lw_ext > 32'(MAXP)) begin
      w_lim = WW'(MAXP);
    end else begin
      w_lim = WW'(lw_ext);
    end
  end

  // range tracking and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      min_re   <= '0;
      max_re   <= '0;
      min_im   <= '0;
      max_im   <= '0;
      smp_cnt  <= '0;
      emit_cnt <= '0;
    end else begin
      if (cmd.range_upd) begin
        if (smp_cnt == '0) begin
          min_re <= re;
          max_re <= re;
          min_im <= im;
          max_im <= im;
        end else begin
          if (re < min_re) min_re <= re;
          if (re > max_re) max_re <= re;
          if (im < min_im) min_im <= im;
          if (im > max_im) max_im <= im;
        end
        smp_cnt <= smp_cnt + CW'(1);
      end
      if (cmd.emit_inc) begin
        emit_cnt <= emit_cnt + CW'(1);
      end
    end
  end

  // request capture and scaling operands
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      re <= req.sample_real[SW-1:0];
      im <= req.sample_imag[SW-1:0];
    end
    if (cmd.emit_inc) begin
      diff_re <= $unsigned(re - min_re);
      rng_re  <= $unsigned(max_re - min_re);
      zero_re <= (max_re <= min_re) || (re < min_re);
      sat_re  <= (re > max_re);
      diff_im <= $unsigned(im - min_im);
      rng_im  <= $unsigned(max_im - min_im);
      zero_im <= (max_im <= min_im) || (im < min_im);
      sat_im  <= (im > max_im);
      w_eff   <= w_lim;
      cplx    <= complex_mode;
      blue    <= BYTE_ZERO;
    end
    if (cmd.scale) begin
      // diff * 255 as a shift and subtract
      num_re <= {diff_re, 8'b0} - NUMW'(diff_re);
      num_im <= {diff_im, 8'b0} - NUMW'(diff_im);
    end
    if (cmd.take) begin
      unique case (cmd.div_sel)
        DIV_MOD: pos <= d_rem[WW-1:0];
        DIV_RE:  green <= zero_re ? BYTE_ZERO : (sat_re ? BYTE_MAX : d_quo[7:0]);
        DIV_IM:  blue  <= zero_im ? BYTE_ZERO : (sat_im ? BYTE_MAX : d_quo[7:0]);
        default: pos <= pos;
      endcase
    end
  end

  // divider operand select: count mod width, or scaled difference over range
  always_comb begin
    unique case (cmd.div_sel)
      DIV_RE: begin
        d_rem_init = DW'(num_re[NUMW-1:8]);
        d_bits     = {num_re[7:0], {(NW-8){1'b0}}};
        d_steps    = SCW'(8);
        d_divisor  = DW'(rng_re);
      end
      DIV_IM: begin
        d_rem_init = DW'(num_im[NUMW-1:8]);
        d_bits     = {num_im[7:0], {(NW-8){1'b0}}};
        d_steps    = SCW'(8);
        d_divisor  = DW'(rng_im);
      end
      default: begin
        d_rem_init = '0;
        d_bits     = emit_cnt;
        d_steps    = SCW'(NW);
        d_divisor  = DW'(w_eff);
      end
    endcase
  end

  srn_div #(
    .DW  (DW),
    .NW  (NW),
    .SCW (SCW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .rem_init  (d_rem_init),
    .bits_init (d_bits),
    .steps     (d_steps),
    .divisor   (d_divisor),
    .done      (d_done),
    .rem       (d_rem),
    .quo       (d_quo)
  );

  assign status.div_done = d_done;
  assign status.cplx     = cplx;

  // red byte, last row fill and row padding
  always_comb begin
    last = (emit_cnt == smp_cnt);
    wp   = w_eff - pos;
    zsum = ZW'(1);
    if (last) begin
      zsum = zsum + ZW'(wp) + ZW'({wp, 1'b0});
    end
    if ((pos == '0) || last) begin
      zsum = zsum + ZW'(2'(w_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out) begin
      res.blue_byte  <= blue;
      res.green_byte <= green;
      res.zero_bytes <= ZERO_BYTES_BITS'(zsum);
    end
  end

endmodule
